@@ src/tach_pkg.sv @@
package tach_pkg;

  // Fixed field widths of the block.
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned RPM_W       = 32;
  localparam int unsigned DEB_W       = 16;
  localparam int unsigned ALPHA_W     = 17;
  localparam int unsigned ALPHA_BITS  = 16;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  // 15000000 << 8: rpm at four sensor pulses per revolution, 8 fractional bits.
  localparam logic [RPM_W-1:0] RPM_NUMERATOR = 32'd3840000000;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [DEB_W-1:0]   DEB_RESET   = 16'd800;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd13107;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 8'd1;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ src/tach_div.sv @@
module tach_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tach_pkg::RPM_W-1:0]  dividend,
  input  logic [tach_pkg::TIME_W-1:0] divisor,
  output tach_pkg::div_sts_t          sts,
  output logic [tach_pkg::RPM_W-1:0]  quotient
);

  localparam int unsigned N     = tach_pkg::RPM_W;
  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [N-1:0]                quo_r, quo_nxt;
  logic [tach_pkg::TIME_W:0]   rem_r, rem_nxt;
  logic [tach_pkg::TIME_W-1:0] den_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  logic [tach_pkg::TIME_W:0]   shifted;
  logic [tach_pkg::TIME_W+1:0] trial;

  // One restoring step per cycle on a shared subtractor.
  assign shifted = {rem_r[tach_pkg::TIME_W-1:0], quo_r[N-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[tach_pkg::TIME_W+1]) begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[N-2:0], 1'b0};
      end else begin
        rem_nxt = trial[tach_pkg::TIME_W:0];
        quo_nxt = {quo_r[N-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

@@ src/tachometer_rpm_smoother_core.sv @@
// Channel | Direction | Transfer content
// in_     | slave     | tdata[31:0] edge_time_us
// out_    | master    | tuser accepted; tdata period_us, rpm_sample, rpm_average
// cfg_    | slave     | cfg_index (0 debounce_us, 1 smoothing_alpha), cfg_data
//
// An accepted edge passes from input transfer to result through the debounce
// compare, the bit-serial restoring divider, and then the difference, the
// alpha multiply, the accumulate and the output load. A rejected edge goes
// from the debounce compare straight to the output load. One item at a time;
// in_tready is high only in idle, so the next input transfer comes in the cycle
// after the result loads at the earliest.
// A result waits in the output register while out_tready is low, and the next
// result holds in its last state until that register is free.
// rst_n is synchronous, active low, and restores the register defaults.
module tachometer_rpm_smoother_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] edge_time_us
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata,  // [31:0] period_us,
                                                        // [63:32] rpm_sample,
                                                        // [95:64] rpm_average
  output logic                              out_tuser,  // [0] accepted
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tach_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tach_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  localparam int unsigned TW = tach_pkg::TIME_W;
  localparam int unsigned RW = tach_pkg::RPM_W;
  localparam int unsigned AW = tach_pkg::ALPHA_W;
  localparam int unsigned PW = RW + 1 + AW + 1;

  state_t state_r;

  logic [tach_pkg::DEB_W-1:0]   debounce_r;
  logic [AW-1:0]                alpha_r;
  logic [TW-1:0]                last_edge_r;
  logic [TW-1:0]                last_period_r;
  logic [RW-1:0]                avg_r;

  logic [TW-1:0]                now_r;
  logic [TW-1:0]                elapsed_r;
  logic [RW-1:0]                sample_r;
  logic signed [RW:0]           diff_r;
  logic signed [PW-1:0]         prod_r;
  logic                         acc_ok_r;

  logic                         out_tvalid_r;
  logic                         out_acc_r;
  logic [TW-1:0]                out_period_r;
  logic [RW-1:0]                out_sample_r;
  logic [RW-1:0]                out_avg_r;

  logic                         div_start;
  logic [TW-1:0]                div_den;
  tach_pkg::div_sts_t           div_sts;
  logic [RW-1:0]                div_quo;

  logic [AW-1:0]                alpha_sat;
  logic                         out_free;
  logic [RW-1:0]                avg_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  // Saturate alpha above one.
  assign alpha_sat = (alpha_r > tach_pkg::ALPHA_ONE) ? tach_pkg::ALPHA_ONE : alpha_r;

  // Start the divide on a passing edge; zero elapsed divides by one.
  assign div_start = (state_r == S_CHECK) && (elapsed_r >= TW'(debounce_r));
  assign div_den   = (elapsed_r == '0) ? TW'(1) : elapsed_r;

  // avg + floor((sample - avg) * alpha / 2^16) equals the truncated blend.
  assign avg_nxt = avg_r + prod_r[tach_pkg::ALPHA_BITS +: RW];

  tach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tach_pkg::RPM_NUMERATOR),
    .divisor  (div_den),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      debounce_r    <= tach_pkg::DEB_RESET;
      alpha_r       <= tach_pkg::ALPHA_RESET;
      last_edge_r   <= '0;
      last_period_r <= '0;
      avg_r         <= '0;
      out_tvalid_r  <= 1'b0;
      acc_ok_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tach_pkg::REG_DEBOUNCE: debounce_r <= cfg_data[tach_pkg::DEB_W-1:0];
          tach_pkg::REG_ALPHA:    alpha_r    <= cfg_data[AW-1:0];
          default: ;
        endcase
      end

      // Drop valid after the transfer unless a new result loads this cycle.
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            now_r     <= in_tdata;
            elapsed_r <= in_tdata - last_edge_r;
            state_r   <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Reject: hold all state, report zero sample.
          if (div_start) begin
            last_period_r <= elapsed_r;
            last_edge_r   <= now_r;
            acc_ok_r      <= 1'b1;
            state_r       <= S_DIV;
          end else begin
            acc_ok_r <= 1'b0;
            sample_r <= '0;
            state_r  <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            sample_r <= div_quo;
            state_r  <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_r  <= $signed({1'b0, sample_r}) - $signed({1'b0, avg_r});
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PW'(diff_r * $signed({1'b0, alpha_sat}));
          state_r <= S_ACC;
        end
        S_ACC: begin
          avg_r   <= avg_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Advance only once the output register is free.
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_acc_r    <= acc_ok_r;
            out_period_r <= last_period_r;
            out_sample_r <= sample_r;
            out_avg_r    <= avg_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_acc_r;
  assign out_tdata  = {out_avg_r, out_sample_r, out_period_r};

endmodule

@@ src/tach_checker.sv @@
module tach_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  // One edge in flight: input closes after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an edge is in flight");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed under stall");

  // A rejected edge reports a zero sample.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[63:32] == 32'd0))
    else $error("rejected edge with nonzero sample");

  // A result never appears in the cycle right after an input transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too soon after input transfer");

endmodule

bind tachometer_rpm_smoother_core tach_checker u_tach_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ bench/tach_rpm_checker.sv @@
module tach_rpm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] edge_time_us
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [95:0]                     out_tdata,  // [31:0] period_us, [63:32] rpm_sample,
                                                      // [95:64] rpm_average
  input  logic                            out_tuser,  // [0] accepted
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tach_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        accepted;
    logic [31:0] period_us;
    logic [31:0] rpm_sample;
    logic [31:0] rpm_average;
  } tach_reading_t;

  // 15e6 rpm-us at four sensor pulses per revolution, scaled by 2^8.
  localparam logic [63:0] RPM_DIVIDEND      = 64'd3_840_000_000;
  localparam logic [16:0] UNITY_WEIGHT      = 17'h1_0000;
  localparam logic [15:0] DEBOUNCE_AT_RESET = 16'd800;
  localparam logic [16:0] WEIGHT_AT_RESET   = 17'd13107;

  logic [15:0]   min_gap_us;
  logic [16:0]   new_weight;
  logic [31:0]   prev_edge_us;
  logic [31:0]   held_period_us;
  logic [31:0]   avg_rpm;
  tach_reading_t expected_readings[$];

  function automatic tach_reading_t next_reading(input logic [31:0] edge_us);
    tach_reading_t r;
    logic [31:0]   elapsed;
    logic [63:0]   quotient;
    logic [63:0]   blend;
    logic [16:0]   w;
    elapsed       = edge_us - prev_edge_us;
    r.accepted    = 1'b0;
    r.period_us   = held_period_us;
    r.rpm_sample  = '0;
    r.rpm_average = avg_rpm;
    if (elapsed >= 32'(min_gap_us)) begin
      held_period_us = elapsed;
      prev_edge_us   = edge_us;
      // zero gap only gets through with debounce at zero; divide by one then
      quotient = RPM_DIVIDEND / ((elapsed == '0) ? 64'd1 : 64'(elapsed));
      if (quotient > 64'hFFFF_FFFF) begin
        quotient = 64'hFFFF_FFFF;
      end
      w       = (new_weight > UNITY_WEIGHT) ? UNITY_WEIGHT : new_weight;
      blend   = quotient * 64'(w) + 64'(avg_rpm) * 64'(UNITY_WEIGHT - w);
      avg_rpm = blend[47:16];
      r.accepted    = 1'b1;
      r.period_us   = elapsed;
      r.rpm_sample  = quotient[31:0];
      r.rpm_average = avg_rpm;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    tach_reading_t want;
    if (!rst_n) begin
      min_gap_us     = DEBOUNCE_AT_RESET;
      new_weight     = WEIGHT_AT_RESET;
      prev_edge_us   = '0;
      held_period_us = '0;
      avg_rpm        = '0;
      mismatches     = 0;
      expected_readings.delete();
    end else begin
      // retire before queueing, so a same-edge input never matches itself
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result transfer with no edge outstanding: tdata %h tuser %b",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(out_tuser));
          check_field("period_us", want.period_us, out_tdata[31:0]);
          check_field("rpm_sample", want.rpm_sample, out_tdata[63:32]);
          check_field("rpm_average", want.rpm_average, out_tdata[95:64]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tach_pkg::REG_DEBOUNCE: min_gap_us = cfg_data[15:0];
          tach_pkg::REG_ALPHA:    new_weight = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(next_reading(in_tdata));
      end
    end
    in_flight = expected_readings.size();
  end

endmodule

@@ bench/tb_tachometer_rpm_smoother_core.sv @@
module tb_tachometer_rpm_smoother_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes outside the map; the block must drop these writes.
  localparam logic [tach_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
  localparam logic [tach_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

  localparam int RANDOM_EDGES = 228;  // per random phase, three phases
  localparam int HOLD_CYCLES  = 400;  // long result back-pressure stretch
  localparam int STALL_LIMIT  = 4000; // cycles with no transfer at all
  localparam int DRAIN_TAIL   = 60;   // watch after the drain for stray results

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [31:0]                     in_tdata;   // [31:0] edge_time_us
  logic                            out_tvalid;
  logic                            out_tready;
  logic [95:0]                     out_tdata;  // [31:0] period_us, [63:32] rpm_sample,
                                               // [95:64] rpm_average
  logic                            out_tuser;  // [0] accepted
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tach_pkg::CFG_DATA_W-1:0] cfg_data;

  int          mismatches;
  int          in_flight;
  int          tx_idle_pct  = 28;
  int          rx_idle_pct  = 71;
  int          hold_token   = 0;     // bumped by the sender side to request a hold
  int          hold_seen    = 0;     // owned by the receiver process
  int          quiet_cycles = 0;
  logic [31:0] last_sent_us = '0;
  logic [15:0] deb_now      = 16'd800;

  tachometer_rpm_smoother_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tach_rpm_checker rpm_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // 4 ns period, first rising edge at 2 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: accept at the phase's idle rate. When a hold is requested,
  // drop tready for a long stretch so the block fills and stalls its input.
  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Abort when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL tachometer_rpm_smoother_core");
      $finish;
    end
  end

  // Offer one edge, idling first at the sender's rate; return at the edge
  // that completes the transfer, with tvalid still high.
  task automatic send_edge(input logic [31:0] t);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    last_sent_us = t;
    do @(posedge clk); while (!in_tready);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no second assignment.
  task automatic write_reg(input logic [tach_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write both registers with junk above the used bits, then release the channel.
  task automatic set_config(input logic [15:0] deb, input logic [16:0] alpha);
    write_reg(tach_pkg::REG_DEBOUNCE, ($urandom & 32'hFFFF_0000) | 32'(deb));
    write_reg(tach_pkg::REG_ALPHA, ($urandom & 32'hFFFE_0000) | 32'(alpha));
    cfg_valid <= 1'b0;
    deb_now = deb;
  endtask

  // Wait until every result has come back, switch idle rates, realign to a
  // rising edge. Every edge yields a result, so an empty queue means idle.
  task automatic settle(input int tx_pct, input int rx_pct);
    do @(negedge clk); while (in_flight != 0);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    @(posedge clk);
  endtask

  // Mostly plausible edge trains spaced past the debounce window, plus
  // bounces, edges right at the threshold, wild gaps and unrelated timestamps.
  task automatic run_random(input int count, input bit with_hold);
    int          mode;
    logic [31:0] delta;
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == count / 2) begin
        hold_token <= hold_token + 1;
      end
      mode = $urandom_range(99);
      if (mode < 60) begin
        delta = 32'(deb_now) + $urandom_range(20000);
      end else if (mode < 70) begin
        delta = (deb_now == '0) ? 32'd0 : $urandom_range(32'(deb_now) - 1);
      end else if (mode < 80) begin
        delta = 32'(deb_now) - $urandom_range(1);
      end else if (mode < 90) begin
        delta = $urandom;
      end else begin
        delta = $urandom - last_sent_us;
      end
      send_edge(last_sent_us + delta);
    end
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: debounce 800, alpha about 0.2, all state zero.
    send_edge(32'd0);             // zero gap from reset time, rejected
    send_edge(32'd799);           // one short of the window
    send_edge(32'd800);           // exactly at the window
    send_edge(32'd1599);
    send_edge(32'd1600);
    send_edge(32'hFFFF_FF00);     // huge gap, sample near zero
    send_edge(32'h0000_0400);     // timestamp wraps
    send_edge(32'hFFFF_FFFF);
    send_edge(32'h0000_031F);     // wraps again, gap of exactly 800
    in_tvalid <= 1'b0;

    // Debounce off and full weight: a repeated timestamp divides by one.
    settle(28, 71);
    set_config(16'd0, 17'h1_0000);
    send_edge(32'h0000_031F);
    send_edge(32'h0000_0320);
    in_tvalid <= 1'b0;

    // Weight above one saturates; a repeat now bounces.
    settle(28, 71);
    set_config(16'd1, 17'h1_FFFF);
    send_edge(32'h0000_0322);
    send_edge(32'h0000_0322);
    in_tvalid <= 1'b0;

    // Unmapped indexes first, then widest window and zero weight (average holds).
    settle(28, 71);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    set_config(16'hFFFF, 17'd0);
    send_edge(32'h0000_0322 + 32'd65534);
    send_edge(32'h0000_0322 + 32'd65535);
    send_edge(32'h7FFF_0322 + 32'd65535);
    in_tvalid <= 1'b0;

    settle(28, 71);
    set_config(16'd800, 17'd13107);
    send_edge(32'h5555_5555);
    send_edge(32'hAAAA_AAAA);
    in_tvalid <= 1'b0;

    // Sender mostly active, receiver mostly stalled.
    settle(28, 71);
    set_config(16'($urandom_range(1, 4000)), 17'($urandom_range(65536)));
    run_random(RANDOM_EDGES, 1'b0);
    in_tvalid <= 1'b0;

    // Roles swapped, with one long receiver hold in the middle.
    settle(71, 28);
    set_config(16'd800, 17'd13107);
    run_random(RANDOM_EDGES, 1'b1);
    in_tvalid <= 1'b0;

    // Full rate on both sides.
    settle(0, 0);
    set_config(16'd1, 17'($urandom_range(131071)));
    run_random(RANDOM_EDGES, 1'b0);
    in_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    settle(0, 0);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("PASS tachometer_rpm_smoother_core");
    end else begin
      $display("FAIL tachometer_rpm_smoother_core");
    end
    $finish;
  end

endmodule

@@ tachometer_rpm_smoother_core.f @@
src/tach_pkg.sv
src/tach_div.sv
src/tachometer_rpm_smoother_core.sv
src/tach_checker.sv
bench/tach_rpm_checker.sv
bench/tb_tachometer_rpm_smoother_core.sv
